// File: hw/rtl/square_occupancy_placement_map_assert.svh
// Assertion macros used by the map's datapath.
// Every macro samples on aclk and is switched off while aresetn is low.
`ifndef SQUARE_OCCUPANCY_PLACEMENT_MAP_ASSERT_SVH
`define SQUARE_OCCUPANCY_PLACEMENT_MAP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SOPM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("square occupancy map: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SOPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("square occupancy map: next-cycle check failed");

`endif

// File: hw/rtl/sopm_pkg.sv
package sopm_pkg;

    localparam int GRID_SIDE = 32;
    localparam int COORD_W   = $clog2(GRID_SIDE);
    localparam int LEN_W     = COORD_W + 1;
    localparam int ROW_W     = GRID_SIDE;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;

    localparam logic [1:0] REQ_MARK   = 2'd0;
    localparam logic [1:0] REQ_TEST   = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mark_row;
        logic scan_row;
        logic finish;
        logic emit_nofit;
        logic next_cand;
    } cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic [1:0] req_type;
        logic       no_fit;
        logic       cnt_zero;
        logic       cnt_one;
        logic       out_last;
    } status_t;

endpackage

// File: hw/rtl/sopm_datapath.sv
`include "square_occupancy_placement_map_assert.svh"

module sopm_datapath
    import sopm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic [IN_USER_W-1:0]   s_tuser,
    input  logic [IN_DATA_W-1:0]   s_tdata,
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tlast
);

    // Ones in bits 0 .. n-1; n of GRID_SIDE or more gives a full row.
    function automatic logic [ROW_W-1:0] low_ones(input logic [LEN_W-1:0] n);
        logic [ROW_W:0] t;
        t = ({{ROW_W{1'b0}}, 1'b1} << n) - {{ROW_W{1'b0}}, 1'b1};
        return (n >= LEN_W'(GRID_SIDE)) ? {ROW_W{1'b1}} : t[ROW_W-1:0];
    endfunction

    localparam logic [LEN_W:0]   GRID_W1 = (LEN_W + 1)'(GRID_SIDE);
    localparam logic [LEN_W-1:0] ONE_L   = LEN_W'(1);

    logic [ROW_W-1:0] occ_reg [GRID_SIDE];

    logic [1:0]         req_reg,    req_next;
    logic [LEN_W-1:0]   s_reg,      s_next;
    logic [ROW_W-1:0]   span_reg,   span_next;
    logic [ROW_W-1:0]   win_reg,    win_next;
    logic [COORD_W-1:0] top_i_reg,  top_i_next;
    logic               no_fit_reg, no_fit_next;
    logic [COORD_W-1:0] cand_reg,   cand_next;
    logic [COORD_W-1:0] rd_reg,     rd_next;
    logic [LEN_W-1:0]   cnt_reg,    cnt_next;
    logic [ROW_W-1:0]   acc_reg,    acc_next;
    logic               free_reg,   free_next;
    logic [COORD_W-1:0] rs_reg,     rs_next;
    logic [ROW_W-1:0]   cm_reg,     cm_next;
    logic               last_reg,   last_next;

    logic [COORD_W-1:0] in_x, in_y;
    logic [LEN_W-1:0]   in_side, in_w, in_h, in_se;
    logic [LEN_W:0]     xs7, ys7, xw7, yh7, xse7, yse7;
    logic [LEN_W-1:0]   hi_x, hi_y, lim_i, lim_j, cnt_mt, top_j, top_i6;
    logic               colok;
    logic [ROW_W-1:0]   span_in, win_in, row_rd, erode;

    assign in_x    = s_tdata[4:0];
    assign in_y    = s_tdata[9:5];
    assign in_side = s_tdata[15:10];
    assign in_w    = s_tdata[21:16];
    assign in_h    = s_tdata[27:22];
    assign in_se   = (in_side == '0) ? ONE_L : in_side;

    // Request decode, settled while the beat is taken.
    always_comb begin
        xs7    = {2'b00, in_x} + {1'b0, in_side};
        ys7    = {2'b00, in_y} + {1'b0, in_side};
        xw7    = {2'b00, in_x} + {1'b0, in_w};
        yh7    = {2'b00, in_y} + {1'b0, in_h};
        xse7   = {2'b00, in_x} + {1'b0, in_se};
        yse7   = {2'b00, in_y} + {1'b0, in_se};
        hi_x   = (xs7 > GRID_W1) ? LEN_W'(GRID_SIDE) : xs7[LEN_W-1:0];
        hi_y   = (ys7 > GRID_W1) ? LEN_W'(GRID_SIDE) : ys7[LEN_W-1:0];
        lim_i  = (xw7 > GRID_W1) ? LEN_W'(GRID_SIDE) : xw7[LEN_W-1:0];
        lim_j  = (yh7 > GRID_W1) ? LEN_W'(GRID_SIDE) : yh7[LEN_W-1:0];
        cnt_mt = hi_x - {1'b0, in_x};
        span_in = low_ones(hi_y) & ~low_ones({1'b0, in_y});
        top_i6 = lim_i - in_se;
        top_j  = lim_j - in_se;
        colok  = yse7 <= {1'b0, lim_j};
        win_in = colok ? (low_ones(top_j + ONE_L) & ~low_ones({1'b0, in_y})) : '0;
    end

    assign row_rd = occ_reg[rd_reg];

    // Columns whose run of s_reg cells is free in the accumulated union,
    // built from power-of-two runs picked by the bits of the side length.
    always_comb begin
        logic [ROW_W-1:0] pw;
        logic [LEN_W-1:0] off;
        pw    = ~acc_reg;
        erode = {ROW_W{1'b1}};
        off   = '0;
        for (int b = 0; b < LEN_W; b++) begin
            if (s_reg[b]) begin
                erode = erode & (pw >> off);
                off   = off + LEN_W'(1 << b);
            end
            pw = pw & (pw >> (1 << b));
        end
    end

    always_comb begin
        req_next    = req_reg;
        s_next      = s_reg;
        span_next   = span_reg;
        win_next    = win_reg;
        top_i_next  = top_i_reg;
        no_fit_next = no_fit_reg;
        cand_next   = cand_reg;
        rd_next     = rd_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        free_next   = free_reg;
        rs_next     = rs_reg;
        cm_next     = cm_reg;
        last_next   = last_reg;
        if (cmd.load) begin
            req_next    = s_tuser;
            s_next      = in_side;
            span_next   = span_in;
            win_next    = win_in;
            top_i_next  = top_i6[COORD_W-1:0];
            no_fit_next = xse7 > {1'b0, lim_i};
            cand_next   = in_x;
            rd_next     = in_x;
            cnt_next    = (s_tuser == REQ_SEARCH) ? in_side : cnt_mt;
            acc_next    = '0;
        end
        if (cmd.mark_row || cmd.scan_row) begin
            rd_next  = rd_reg + COORD_W'(1);
            cnt_next = cnt_reg - ONE_L;
        end
        if (cmd.scan_row) begin
            acc_next = acc_reg | row_rd;
        end
        if (cmd.finish) begin
            if (req_reg == REQ_TEST) begin
                free_next = (acc_reg & span_reg) == '0;
                rs_next   = '0;
                cm_next   = '0;
                last_next = 1'b1;
            end else begin
                free_next = 1'b0;
                rs_next   = cand_reg;
                cm_next   = erode & win_reg;
                last_next = cand_reg == top_i_reg;
            end
        end
        if (cmd.emit_nofit) begin
            free_next = 1'b0;
            rs_next   = cand_reg;
            cm_next   = '0;
            last_next = 1'b1;
        end
        if (cmd.next_cand) begin
            cand_next = cand_reg + COORD_W'(1);
            rd_next   = cand_reg + COORD_W'(1);
            cnt_next  = s_reg;
            acc_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < GRID_SIDE; i++) begin
                occ_reg[i] <= '0;
            end
        end else if (cmd.mark_row) begin
            occ_reg[rd_reg] <= row_rd | span_reg;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        s_reg      <= s_next;
        span_reg   <= span_next;
        win_reg    <= win_next;
        top_i_reg  <= top_i_next;
        no_fit_reg <= no_fit_next;
        cand_reg   <= cand_next;
        rd_reg     <= rd_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        free_reg   <= free_next;
        rs_reg     <= rs_next;
        cm_reg     <= cm_next;
        last_reg   <= last_next;
    end

    assign status.req_type = req_reg;
    assign status.no_fit   = no_fit_reg;
    assign status.cnt_zero = cnt_reg == '0;
    assign status.cnt_one  = cnt_reg == ONE_L;
    assign status.out_last = last_reg;

    assign m_tdata = {2'b00, cm_reg, rs_reg, free_reg};
    assign m_tlast = last_reg;

    `SOPM_ASSERT_NOW(a_mark_rows_left, cmd.mark_row, cnt_reg != '0)
    `SOPM_ASSERT_NOW(a_finish_after_rows, cmd.finish, cnt_reg == '0)
    `SOPM_ASSERT_NOW(a_next_cand_in_window, cmd.next_cand, cand_reg != top_i_reg)
    `SOPM_ASSERT_NEXT(a_load_sets_row, cmd.load, rd_reg == $past(s_tdata[4:0]))

endmodule

// File: hw/rtl/sopm_ctrl.sv
module sopm_ctrl
    import sopm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_MARK   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0] state_reg, state_next;

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = state_reg == S_OUT;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (status.req_type)
                    REQ_MARK: begin
                        state_next = status.cnt_zero ? S_IDLE : S_MARK;
                    end
                    REQ_TEST: begin
                        state_next = S_SCAN;
                    end
                    REQ_SEARCH: begin
                        if (status.no_fit) begin
                            cmd.emit_nofit = 1'b1;
                            state_next     = S_OUT;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_MARK: begin
                cmd.mark_row = 1'b1;
                if (status.cnt_one) begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                if (status.cnt_zero) begin
                    cmd.finish = 1'b1;
                    state_next = S_OUT;
                end else begin
                    cmd.scan_row = 1'b1;
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    if (status.out_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.next_cand = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/square_occupancy_placement_map.sv
// Square occupancy map over a 32 by 32 grid of cells, all free after reset.
// Each input beat carries one request, selected by s_tuser: mark sets every
// cell of a square (clipped to the grid) and returns nothing; test returns one
// beat whose is_free bit says whether that clipped square holds no set cell;
// search returns one beat per candidate first coordinate of the window, in
// increasing order, each with a mask of second coordinates where a square of
// the given side lies wholly inside window and grid and covers no set cell,
// and m_tlast on the final beat. A search whose window, clipped to the grid,
// is shorter than the side in the first coordinate returns a single beat
// with row_start equal to x_pos, an empty mask and m_tlast set. Request
// codes 3 are dropped without a result. The block works on one request at a
// time: s_tready is high only while nothing is in progress and every result
// of the previous request has been taken. Timing is set by the single bitmap
// read port, which delivers one row per cycle. A mark decodes and then writes
// its rows. A test decodes, scans its rows and then registers its result
// beat. A search decodes and then, for each candidate row, scans side rows
// and registers a result beat, which may wait on m_tready.
module square_occupancy_placement_map
    import sopm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Request channel.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [4:0] x_pos, [9:5] y_pos, [15:10] side, [21:16] win_width,
    // [27:22] win_height, [31:28] zero.
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] req_type.
    input  logic [IN_USER_W-1:0]  s_tuser,
    // Result channel.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] is_free, [5:1] row_start, [37:6] col_mask, [39:38] zero.
    output logic [OUT_DATA_W-1:0] m_tdata,
    // last: final result beat of the request.
    output logic                  m_tlast
);

    cmd_t    cmd;
    status_t status;

    // Sequencer: walks the rows of each request and paces the result beats.
    sopm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Bitmap, row union accumulator, column fit logic and result register.
    sopm_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule
